### src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define IIM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define IIM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/iim_pkg.sv
// ----------------------------------------------------------------------------
// iim_pkg
// Shared constants, types and codes of the interval insert and merge block.
// ----------------------------------------------------------------------------
package iim_pkg;

    // table depth and derived widths
    localparam int CAPACITY = 32;
    localparam int VAL_W    = 32;
    localparam int K_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int N_W      = $clog2(CAPACITY + 2);
    localparam int SUM_W    = CNT_W + 1;

    // one closed interval
    typedef struct packed {
        logic signed [VAL_W-1:0] e;
        logic signed [VAL_W-1:0] s;
    } ival_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_BAD  = 2'd2
    } status_t;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_FLUSH,
        S_DECIDE,
        S_EMIT,
        S_STAT
    } state_t;

    // controls shared by every cell of the chain
    typedef struct packed {
        logic tbl_shift;
        logic wrk_shift;
        logic copy;
    } cell_ctl_t;

    // controls of the merge unit at the head of the chain
    typedef struct packed {
        logic start;
        logic step;
        logic x_valid;
        logic flush;
    } merge_ctl_t;

endpackage

### src/iim_cell.sv
// ----------------------------------------------------------------------------
// iim_cell
// One cell of the chain: a stored interval and a work interval, each loaded
// from the neighbor cell on a shift, plus a local copy from work to table.
// ----------------------------------------------------------------------------
module iim_cell (
    input  logic               clk,
    input  iim_pkg::cell_ctl_t ctl,
    input  iim_pkg::ival_t     tbl_in,
    input  iim_pkg::ival_t     wrk_in,
    output iim_pkg::ival_t     tbl_out,
    output iim_pkg::ival_t     wrk_out
);

    iim_pkg::ival_t tbl_reg;
    iim_pkg::ival_t tbl_next;
    iim_pkg::ival_t wrk_reg;
    iim_pkg::ival_t wrk_next;

    // table slot: rotate along the chain or take the finished work entry
    always_comb
    begin
        tbl_next = tbl_reg;
        if (ctl.copy)
        begin
            tbl_next = wrk_reg;
        end
        else if (ctl.tbl_shift)
        begin
            tbl_next = tbl_in;
        end
    end

    // work slot: shifts only when a new work entry arrives at the tail
    always_comb
    begin
        wrk_next = wrk_reg;
        if (ctl.wrk_shift)
        begin
            wrk_next = wrk_in;
        end
    end

    always_ff @(posedge clk)
    begin
        tbl_reg <= tbl_next;
        wrk_reg <= wrk_next;
    end

    assign tbl_out = tbl_reg;
    assign wrk_out = wrk_reg;

endmodule

### src/iim_merge.sv
// ----------------------------------------------------------------------------
// iim_merge
// Merge unit at the head of the chain. It sees one stored entry per cycle,
// keeps the growing merged interval, places it in order and hands a
// compacted entry stream to the tail of the work chain.
// ----------------------------------------------------------------------------
module iim_merge (
    input  logic                      clk,
    input  logic                      rst_n,
    input  iim_pkg::merge_ctl_t       ctl,
    input  iim_pkg::ival_t            new_ival,
    input  iim_pkg::ival_t            x,
    output logic                      y_valid,
    output iim_pkg::ival_t            y,
    output logic [iim_pkg::N_W-1:0]   n_out
);

    localparam logic [iim_pkg::N_W-1:0] N_ONE = iim_pkg::N_W'(1);

    logic signed [iim_pkg::VAL_W-1:0] ns_reg;
    logic signed [iim_pkg::VAL_W-1:0] ne_reg;
    iim_pkg::ival_t                   hold_reg;
    iim_pkg::ival_t                   hold_next;
    logic                             placed_reg;
    logic                             placed_next;
    logic [iim_pkg::N_W-1:0]          n_reg;
    logic [iim_pkg::N_W-1:0]          n_next;
    logic                             below;
    logic                             above;

    // entry lies wholly before or wholly after the new interval
    assign below = (x.e < ns_reg);
    assign above = (x.s > ne_reg);

    // emitted entry: entries before the insert point pass, after it the
    // hold register acts as a one-entry delay
    always_comb
    begin
        y_valid = 1'b0;
        y       = hold_reg;
        if (ctl.flush)
        begin
            y_valid = 1'b1;
        end
        else if (ctl.step && ctl.x_valid)
        begin
            if (placed_reg || above)
            begin
                y_valid = 1'b1;
            end
            else if (below)
            begin
                y_valid = 1'b1;
                y       = x;
            end
        end
    end

    // hold register and placement flag
    always_comb
    begin
        hold_next   = hold_reg;
        placed_next = placed_reg;
        if (ctl.start)
        begin
            hold_next   = new_ival;
            placed_next = 1'b0;
        end
        else if (ctl.step && ctl.x_valid)
        begin
            if (placed_reg || above)
            begin
                hold_next   = x;
                placed_next = 1'b1;
            end
            else if (!below)
            begin
                // overlapping or touching entry widens the merged interval
                hold_next.s = (x.s < hold_reg.s) ? x.s : hold_reg.s;
                hold_next.e = (x.e > hold_reg.e) ? x.e : hold_reg.e;
            end
        end
    end

    // count of entries handed to the work chain
    always_comb
    begin
        n_next = n_reg;
        if (ctl.start)
        begin
            n_next = '0;
        end
        else if (y_valid)
        begin
            n_next = n_reg + N_ONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            placed_reg <= 1'b0;
            n_reg      <= '0;
        end
        else
        begin
            placed_reg <= placed_next;
            n_reg      <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
        if (ctl.start)
        begin
            ns_reg <= new_ival.s;
            ne_reg <= new_ival.e;
        end
    end

    assign n_out = n_reg;

endmodule

### src/interval_insert_merge_top.sv
// ----------------------------------------------------------------------------
// interval_insert_merge_top
// Sorted table of disjoint closed intervals with insert, merge and readout.
// ----------------------------------------------------------------------------
// Usage
//   Input stream s_*: one item is one interval, new_start in tdata[31:0],
//   new_end in tdata[63:32]. Output stream m_*: one item per table entry,
//   entry_start in tdata[31:0], entry_end in tdata[63:32], tuser the status
//   and tlast on the final item of each input.
//   Each input walks the whole chain of CAPACITY cells once through the merge
//   unit, is flushed and committed, then rotates the chain again to read the
//   table out, the readout pausing while the receiver stalls; a rejected
//   input (start above end) goes straight to its status item.
//   A full table or a rejected input gives a single status item with zero
//   data and tlast set; the table is then unchanged.
//   The output register holds its item while m_tready is low and the chain
//   waits; the next input is taken as soon as the last item is loaded.
//   Reset empties the table (entry count zero) and clears the handshakes;
//   the cell contents are not cleared and are never read before written.
// ----------------------------------------------------------------------------
module interval_insert_merge_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // new_start[31:0], new_end[63:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // entry_start[31:0], entry_end[63:32]
    output logic        m_tlast,
    output logic [1:0]  m_tuser    // status[1:0]
);

    localparam int CAP = iim_pkg::CAPACITY;
    localparam logic [iim_pkg::K_W-1:0]   LAST_K  = iim_pkg::K_W'(CAP - 1);
    localparam logic [iim_pkg::K_W-1:0]   K_ONE   = iim_pkg::K_W'(1);
    localparam logic [iim_pkg::N_W-1:0]   N_CAP   = iim_pkg::N_W'(CAP);
    localparam logic [iim_pkg::SUM_W-1:0] SUM_CAP = iim_pkg::SUM_W'(CAP);

    iim_pkg::state_t              state_reg;
    iim_pkg::state_t              state_next;
    logic [iim_pkg::K_W-1:0]      k_reg;
    logic [iim_pkg::K_W-1:0]      k_next;
    logic [iim_pkg::CNT_W-1:0]    count_reg;
    logic [iim_pkg::CNT_W-1:0]    count_next;
    iim_pkg::status_t             stat_reg;
    iim_pkg::status_t             stat_next;

    logic                         m_tvalid_reg;
    logic                         m_tvalid_next;
    iim_pkg::ival_t               m_ival_reg;
    logic                         m_tlast_reg;
    iim_pkg::status_t             m_status_reg;

    iim_pkg::ival_t               new_ival;
    logic                         bad_in;
    iim_pkg::ival_t               tbl_q [CAP];
    iim_pkg::ival_t               wrk_q [CAP];
    iim_pkg::cell_ctl_t           cell_ctl;
    iim_pkg::merge_ctl_t          merge_ctl;
    logic                         y_valid;
    iim_pkg::ival_t               y;
    logic [iim_pkg::N_W-1:0]      n_cnt;
    logic                         overflow;
    logic                         head_live;
    logic                         out_free;
    logic                         step_go;
    logic                         load_entry;
    logic                         load_stat;
    logic                         in_ready;

    // input unpack and order check
    assign new_ival = s_tdata;
    assign bad_in   = (new_ival.s > new_ival.e);

    // valid entries sit right-aligned in the chain: the head holds a live
    // entry once CAP - count steps have passed
    assign head_live = ((iim_pkg::SUM_W'(k_reg) + iim_pkg::SUM_W'(count_reg)) >= SUM_CAP);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign step_go   = !head_live || out_free;
    assign overflow  = (n_cnt > N_CAP);

    // chain of cells: table rotates from head to tail, work fills at tail
    for (genvar i = 0; i < CAP; i++)
    begin : g_cell
        if (i == CAP - 1)
        begin : g_tail
            iim_cell u_cell (
                .clk     (clk),
                .ctl     (cell_ctl),
                .tbl_in  (tbl_q[0]),
                .wrk_in  (y),
                .tbl_out (tbl_q[i]),
                .wrk_out (wrk_q[i])
            );
        end
        else
        begin : g_body
            iim_cell u_cell (
                .clk     (clk),
                .ctl     (cell_ctl),
                .tbl_in  (tbl_q[i+1]),
                .wrk_in  (wrk_q[i+1]),
                .tbl_out (tbl_q[i]),
                .wrk_out (wrk_q[i])
            );
        end
    end

    // merge unit fed by the head cell
    iim_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (merge_ctl),
        .new_ival (new_ival),
        .x        (tbl_q[0]),
        .y_valid  (y_valid),
        .y        (y),
        .n_out    (n_cnt)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            iim_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = bad_in ? iim_pkg::S_STAT : iim_pkg::S_WALK;
                end
            end
            iim_pkg::S_WALK:
            begin
                if (k_reg == LAST_K)
                begin
                    state_next = iim_pkg::S_FLUSH;
                end
            end
            iim_pkg::S_FLUSH:
            begin
                state_next = iim_pkg::S_DECIDE;
            end
            iim_pkg::S_DECIDE:
            begin
                state_next = overflow ? iim_pkg::S_STAT : iim_pkg::S_EMIT;
            end
            iim_pkg::S_EMIT:
            begin
                if (step_go && (k_reg == LAST_K))
                begin
                    state_next = iim_pkg::S_IDLE;
                end
            end
            iim_pkg::S_STAT:
            begin
                if (out_free)
                begin
                    state_next = iim_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = iim_pkg::S_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        in_ready   = 1'b0;
        cell_ctl   = '0;
        merge_ctl  = '0;
        load_entry = 1'b0;
        load_stat  = 1'b0;
        case (state_reg)
            iim_pkg::S_IDLE:
            begin
                in_ready        = 1'b1;
                merge_ctl.start = s_tvalid && !bad_in;
            end
            iim_pkg::S_WALK:
            begin
                cell_ctl.tbl_shift = 1'b1;
                merge_ctl.step     = 1'b1;
                merge_ctl.x_valid  = head_live;
            end
            iim_pkg::S_FLUSH:
            begin
                merge_ctl.flush = 1'b1;
            end
            iim_pkg::S_DECIDE:
            begin
                cell_ctl.copy = !overflow;
            end
            iim_pkg::S_EMIT:
            begin
                cell_ctl.tbl_shift = step_go;
                load_entry         = head_live && out_free;
            end
            iim_pkg::S_STAT:
            begin
                load_stat = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
        cell_ctl.wrk_shift = y_valid;
    end

    assign s_tready = in_ready;

    // step counter, entry count and pending status
    always_comb
    begin
        k_next     = k_reg;
        count_next = count_reg;
        stat_next  = stat_reg;
        if (state_reg == iim_pkg::S_IDLE)
        begin
            k_next    = '0;
            stat_next = iim_pkg::ST_BAD;
        end
        else if (state_reg == iim_pkg::S_DECIDE)
        begin
            k_next    = '0;
            stat_next = iim_pkg::ST_FULL;
            if (!overflow)
            begin
                count_next = n_cnt[iim_pkg::CNT_W-1:0];
            end
        end
        else if (cell_ctl.tbl_shift)
        begin
            k_next = k_reg + K_ONE;
        end
    end

    // output register handshake
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (load_entry || load_stat)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= iim_pkg::S_IDLE;
            k_reg        <= '0;
            count_reg    <= '0;
            stat_reg     <= iim_pkg::ST_OK;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            k_reg        <= k_next;
            count_reg    <= count_next;
            stat_reg     <= stat_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (load_entry)
        begin
            m_ival_reg   <= tbl_q[0];
            m_tlast_reg  <= (k_reg == LAST_K);
            m_status_reg <= iim_pkg::ST_OK;
        end
        else if (load_stat)
        begin
            m_ival_reg   <= '0;
            m_tlast_reg  <= 1'b1;
            m_status_reg <= stat_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_ival_reg.e, m_ival_reg.s};
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_status_reg;

endmodule

### src/iim_checker.sv
// ----------------------------------------------------------------------------
// iim_checker
// Port-level checks of the interval insert and merge block, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module iim_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic        m_tlast,
    input logic [1:0]  m_tuser
);

    // stalled output item holds
    `IIM_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output item changed while stalled")

    // a status item always closes its input
    `IIM_ASSERT_IMP(a_status_last, m_tvalid && (m_tuser != iim_pkg::ST_OK), m_tlast, "status item without tlast")

    // a status item carries no interval
    `IIM_ASSERT_IMP(a_status_zero, m_tvalid && (m_tuser != iim_pkg::ST_OK), m_tdata == 64'd0, "status item with nonzero data")

    // stored intervals are well formed
    `IIM_ASSERT_IMP(a_entry_order, m_tvalid && (m_tuser == iim_pkg::ST_OK), $signed(m_tdata[31:0]) <= $signed(m_tdata[63:32]), "entry with start above end")

    // no new item is taken while a table readout is still under way
    `IIM_ASSERT_IMP(a_no_take_mid, m_tvalid && !m_tlast, !s_tready, "input ready during table readout")

endmodule

bind interval_insert_merge_top iim_checker u_iim_checker (.*);
